// ----- sv/sparse_complex_row_adder_defines.svh -----
// Assertion macros for the sparse complex row adder.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef SPARSE_COMPLEX_ROW_ADDER_DEFINES_SVH
`define SPARSE_COMPLEX_ROW_ADDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scra assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scra assertion failed");

`endif

// ----- sv/scra_pkg.sv -----
// Shared types and constants of the sparse complex row adder.
// Used by the entry store and the top level; depends on nothing.
package scra_pkg;

    // Command codes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD_A = 2'd1;
    localparam logic [1:0] OP_LOAD_B = 2'd2;
    localparam logic [1:0] OP_ADD    = 2'd3;

    // Fixed field widths and limits.
    localparam int CNT_W    = 7;
    localparam int POS_W    = 12;
    localparam int SUM_W    = 33;
    localparam logic [POS_W-1:0] POS_MAX = 12'd4095;
    localparam logic [CNT_W-1:0] MAX_OUT = 7'd64;

    // One stored non-zero entry.
    typedef struct packed {
        logic [5:0]         col;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_entry;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_MERGE = 4'b1000
    } t_state;

endpackage

// ----- sv/scra_store.sv -----
// Entry store of one matrix: one write port, one read port, registered read.
// Depends on scra_pkg for the entry type.
module scra_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  scra_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output scra_pkg::t_entry o_rdata
);
    import scra_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sparse_complex_row_adder.sv -----
// Top level of the sparse complex row adder: row tables, merge sequencer, output.
// Depends on scra_pkg, scra_store and sparse_complex_row_adder_defines.svh.
//
// Clear commands take effect at their transfer and never raise busy. A load
// raises busy for one cycle, in which it checks the row table entry read at the
// transfer and writes the entry store and the row table, so the next command
// can be transferred only once busy is low again. An add-row command raises
// busy for the table-read state, then one merge step per cycle through the two
// entry stores (each step consumes one or both heads, so rows of na entries in
// A and nb in B take na + nb steps less one for each matched column), then a
// closing step. Results leave on o_valid for exactly one cycle each and the
// receiver cannot stall them; the final result of a command carries o_last,
// and an empty sum gives one result with o_row_empty set. The last result of a
// command is on the ports in the first cycle that busy is low, and a new
// command may be transferred at the end of that cycle.
`include "sparse_complex_row_adder_defines.svh"

module sparse_complex_row_adder #(
    parameter int ROWS    = 64,
    parameter int COLS    = 64,
    parameter int ENTRIES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic [5:0]                   i_row,
    input  logic [5:0]                   i_col,
    input  logic signed [31:0]           i_re_in,
    input  logic signed [31:0]           i_im_in,
    output logic                         o_valid,
    output logic [5:0]                   o_out_col,
    output logic signed [scra_pkg::SUM_W-1:0] o_out_re,
    output logic signed [scra_pkg::SUM_W-1:0] o_out_im,
    output logic [scra_pkg::POS_W-1:0]   o_position,
    output logic                         o_row_empty,
    output logic                         o_last
);
    import scra_pkg::*;

    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW  = $clog2(ENTRIES + 1);
    localparam int RD  = (ROWS < 64) ? ROWS : 64;
    localparam int RIW = (RD > 1) ? $clog2(RD) : 1;
    localparam int SW  = ((IW > CNT_W) ? IW : CNT_W) + 1;

    // One row table entry: first stored index and entry count.
    typedef struct packed {
        logic [IW-1:0]    start;
        logic [CNT_W-1:0] cnt;
    } t_row_ent;

    // Row tables with registered reads, row valid bits and fill counters.
    t_row_ent         r_a_tab [RD];
    t_row_ent         r_b_tab [RD];
    t_row_ent         r_a_tq, r_b_tq;
    logic [RD-1:0]    r_a_rv, r_b_rv;
    logic [FW-1:0]    r_a_fill, r_b_fill;
    logic [POS_W-1:0] r_emit_cnt;

    // Captured command.
    logic [1:0]         r_op;
    logic [5:0]         r_row, r_col;
    logic signed [31:0] r_re, r_im;

    // Sequencer registers.
    t_state           r_state;
    logic [CNT_W-1:0] r_na, r_nb, r_i, r_j, r_n;
    logic [IW-1:0]    r_sa, r_sb;

    // Pending result, held until the next one shows whether it is the last.
    logic             r_pend_v;
    logic [5:0]       r_pend_col;
    logic [SUM_W-1:0] r_pend_re, r_pend_im;
    logic [POS_W-1:0] r_pend_pos;

    // Output registers.
    logic             r_valid, r_empty, r_last;
    logic [5:0]       r_col_o;
    logic [SUM_W-1:0] r_re_o, r_im_o;
    logic [POS_W-1:0] r_pos;

    logic             acc, clr, row_ok, col_ok, load_a, load_b;
    logic [RIW-1:0]   row_idx, cmd_idx;
    logic [CNT_W-1:0] a_cur, b_cur;
    t_row_ent         a_tab_new, b_tab_new;
    t_entry           wr_ent, a_head, b_head;
    logic [IW-1:0]    a_raddr, b_raddr;
    logic [SW-1:0]    a_sum_addr, b_sum_addr;
    logic             av_a, av_b, take_a, take_b, both, finish, keep, emit;
    logic [CNT_W-1:0] n_i, n_j;
    logic [5:0]       em_col;
    logic [SUM_W-1:0] em_re, em_im, sum_re, sum_im;
    logic [POS_W-1:0] n_pos;

    // Command transfer and decode of the captured command.
    assign acc     = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign clr     = acc && (i_operation == OP_CLEAR);
    assign row_idx = i_row[RIW-1:0];
    assign cmd_idx = r_row[RIW-1:0];
    assign row_ok  = (11'(r_row) < 11'(ROWS));
    assign col_ok  = (7'(r_col) < 7'(COLS));

    // Load qualification from the row table entry read at the transfer.
    assign a_cur  = r_a_rv[cmd_idx] ? r_a_tq.cnt : '0;
    assign b_cur  = r_b_rv[cmd_idx] ? r_b_tq.cnt : '0;
    assign load_a = (r_state == ST_LOAD) && (r_op == OP_LOAD_A) && row_ok && col_ok
                    && (r_a_fill < FW'(ENTRIES)) && (a_cur < CNT_W'(COLS));
    assign load_b = (r_state == ST_LOAD) && (r_op == OP_LOAD_B) && row_ok && col_ok
                    && (r_b_fill < FW'(ENTRIES)) && (b_cur < CNT_W'(COLS));
    assign a_tab_new = '{start: (a_cur == '0) ? r_a_fill[IW-1:0] : r_a_tq.start,
                         cnt: a_cur + CNT_W'(1)};
    assign b_tab_new = '{start: (b_cur == '0) ? r_b_fill[IW-1:0] : r_b_tq.start,
                         cnt: b_cur + CNT_W'(1)};
    assign wr_ent = '{col: r_col, re: r_re, im: r_im};

    // Merge step decisions from the current heads of both rows.
    assign av_a   = (r_i < r_na);
    assign av_b   = (r_j < r_nb);
    assign finish = !av_a && !av_b;
    assign both   = av_a && av_b && (a_head.col == b_head.col);
    assign take_a = av_a && (!av_b || (a_head.col < b_head.col));
    assign take_b = av_b && (!av_a || (b_head.col < a_head.col));
    assign sum_re = {a_head.re[31], a_head.re} + {b_head.re[31], b_head.re};
    assign sum_im = {a_head.im[31], a_head.im} + {b_head.im[31], b_head.im};
    assign n_i    = r_i + CNT_W'(take_a || both);
    assign n_j    = r_j + CNT_W'(take_b || both);

    always_comb begin
        if (both) begin
            em_col = a_head.col;
            em_re  = sum_re;
            em_im  = sum_im;
        end else if (take_a) begin
            em_col = a_head.col;
            em_re  = {a_head.re[31], a_head.re};
            em_im  = {a_head.im[31], a_head.im};
        end else begin
            em_col = b_head.col;
            em_re  = {b_head.re[31], b_head.re};
            em_im  = {b_head.im[31], b_head.im};
        end
    end

    assign keep  = !both || (sum_re != '0) || (sum_im != '0);
    assign emit  = (r_state == ST_MERGE) && !finish && keep && (r_n < MAX_OUT);
    assign n_pos = (r_emit_cnt == POS_MAX) ? r_emit_cnt : r_emit_cnt + POS_W'(1);

    // Read addresses: the row start while fetching, the next head while merging.
    assign a_sum_addr = (r_state == ST_FETCH) ? SW'(r_a_tq.start) : SW'(r_sa) + SW'(n_i);
    assign b_sum_addr = (r_state == ST_FETCH) ? SW'(r_b_tq.start) : SW'(r_sb) + SW'(n_j);
    assign a_raddr    = a_sum_addr[IW-1:0];
    assign b_raddr    = b_sum_addr[IW-1:0];

    scra_store #(.DEPTH(ENTRIES), .AW(IW)) u_store_a (
        .i_clk  (i_clk),
        .i_we   (load_a),
        .i_waddr(r_a_fill[IW-1:0]),
        .i_wdata(wr_ent),
        .i_raddr(a_raddr),
        .o_rdata(a_head)
    );

    scra_store #(.DEPTH(ENTRIES), .AW(IW)) u_store_b (
        .i_clk  (i_clk),
        .i_we   (load_b),
        .i_waddr(r_b_fill[IW-1:0]),
        .i_wdata(wr_ent),
        .i_raddr(b_raddr),
        .o_rdata(b_head)
    );

    // Row table memories: written by a load, read every cycle at the input row.
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_tab[cmd_idx] <= a_tab_new;
        end
        if (load_b) begin
            r_b_tab[cmd_idx] <= b_tab_new;
        end
        r_a_tq <= r_a_tab[row_idx];
        r_b_tq <= r_b_tab[row_idx];
    end

    // Row valid bits, fills and the emitted count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_a_rv     <= '0;
            r_b_rv     <= '0;
            r_a_fill   <= '0;
            r_b_fill   <= '0;
            r_emit_cnt <= '0;
        end else begin
            if (load_a) begin
                r_a_rv[cmd_idx] <= 1'b1;
                r_a_fill        <= r_a_fill + FW'(1);
            end
            if (load_b) begin
                r_b_rv[cmd_idx] <= 1'b1;
                r_b_fill        <= r_b_fill + FW'(1);
            end
            if (emit) begin
                r_emit_cnt <= n_pos;
            end
        end
    end

    // Merge sequencer and result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_op  <= i_operation;
                        r_row <= i_row;
                        r_col <= i_col;
                        r_re  <= i_re_in;
                        r_im  <= i_im_in;
                        unique case (i_operation) inside
                            OP_LOAD_A, OP_LOAD_B: r_state <= ST_LOAD;
                            OP_ADD:               r_state <= ST_FETCH;
                            default:              r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_IDLE;
                end
                ST_FETCH: begin
                    r_na     <= (row_ok && r_a_rv[cmd_idx]) ? r_a_tq.cnt : '0;
                    r_nb     <= (row_ok && r_b_rv[cmd_idx]) ? r_b_tq.cnt : '0;
                    r_sa     <= r_a_tq.start;
                    r_sb     <= r_b_tq.start;
                    r_i      <= '0;
                    r_j      <= '0;
                    r_n      <= '0;
                    r_pend_v <= 1'b0;
                    r_state  <= ST_MERGE;
                end
                ST_MERGE: begin
                    if (finish) begin
                        r_valid  <= 1'b1;
                        r_last   <= 1'b1;
                        r_empty  <= !r_pend_v;
                        r_col_o  <= r_pend_v ? r_pend_col : '0;
                        r_re_o   <= r_pend_v ? r_pend_re : '0;
                        r_im_o   <= r_pend_v ? r_pend_im : '0;
                        r_pos    <= r_pend_v ? r_pend_pos : '0;
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_i <= n_i;
                        r_j <= n_j;
                        if (emit) begin
                            r_n        <= r_n + CNT_W'(1);
                            r_valid    <= r_pend_v;
                            r_last     <= 1'b0;
                            r_empty    <= 1'b0;
                            r_col_o    <= r_pend_col;
                            r_re_o     <= r_pend_re;
                            r_im_o     <= r_pend_im;
                            r_pos      <= r_pend_pos;
                            r_pend_v   <= 1'b1;
                            r_pend_col <= em_col;
                            r_pend_re  <= em_re;
                            r_pend_im  <= em_im;
                            r_pend_pos <= n_pos;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_out_col   = r_col_o;
    assign o_out_re    = r_re_o;
    assign o_out_im    = r_im_o;
    assign o_position  = r_pos;
    assign o_row_empty = r_empty;
    assign o_last      = r_last;

    // An empty row is a single, final result at position zero.
    `SCRA_ASSERT_IMPL(a_empty_last, i_clk, i_rst_n, o_valid && o_row_empty, o_last)
    `SCRA_ASSERT_IMPL(a_empty_pos, i_clk, i_rst_n, o_valid && o_row_empty, o_position == '0)
    // A kept entry always has a non-zero position.
    `SCRA_ASSERT_IMPL(a_kept_pos, i_clk, i_rst_n, o_valid && !o_row_empty, o_position != '0)
    // An add-row transfer always occupies the sequencer.
    `SCRA_ASSERT_NEXT(a_add_busy, i_clk, i_rst_n, start && !busy && (i_operation == OP_ADD), busy)
    // The closing result of a command leaves as the sequencer returns to idle.
    `SCRA_ASSERT_NEXT(a_close_out, i_clk, i_rst_n, (r_state == ST_MERGE) && finish, o_valid && o_last && !busy)

endmodule
